// ----- rtl/ffca_pkg.sv -----
`timescale 1ns / 1ps
package ffca_pkg;

  localparam int ArenaBytesDef = 65536;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_BASE  = 2'd0,
    CFG_ARENA = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic        cmd;
    logic [16:0] request_size;
    logic [31:0] block_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic        ok;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_INIT,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_A_SIZE,
    ST_A_LINK,
    ST_F_RD,
    ST_F_CHK,
    ST_F_WALK_RD,
    ST_F_WALK,
    ST_F_INS,
    ST_F_NX_RD,
    ST_F_NX,
    ST_F_PV_RD,
    ST_F_PV,
    ST_F_PV_W,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/ffca_hdr_mem.sv -----
`timescale 1ns / 1ps
module ffca_hdr_mem #(
  parameter int Units = 8192,
  parameter int Aw    = 13,
  parameter int Sw    = 17
) (
  input  logic              clk,
  input  logic              we,
  input  logic [Aw-1:0]     waddr,
  input  logic [Sw+Aw-1:0]  wdata,
  input  logic [Aw-1:0]     raddr,
  output logic [Sw+Aw-1:0]  rdata
);
  logic [Sw+Aw-1:0] mem [Units];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/first_fit_coalescing_allocator.sv -----
`timescale 1ns / 1ps
// Steps: alloc reads and checks free blocks in turn, then splits the fit (if large enough) and
// relinks; free checks, walks the list, inserts and merges; a rejected word ends sooner.
// Throughput: one word at a time; the single header read port paces every list step, and a
// finished word waits in done while the previous result is still held on the output.
// Reset: clears the header memory one unit per cycle, then the init state builds the initial free
// block (none under 16 bytes); an arena_size write repeats that pass. No word is taken meanwhile.
module first_fit_coalescing_allocator
  import ffca_pkg::*;
#(
  parameter int ARENA_BYTES = ffca_pkg::ArenaBytesDef
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffca_pkg::in_word_t   in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ffca_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_wdata
);
  import ffca_pkg::*;

  localparam int Units = ARENA_BYTES / 8;
  localparam int Aw    = $clog2(Units);
  localparam int Sw    = $clog2(ARENA_BYTES) + 1;
  localparam int Ew    = Sw + 1;
  localparam int Mw    = (Ew > 18) ? Ew : 18;
  localparam int Cw    = Aw + 1;
  localparam logic [Cw-1:0] WalkLimit = Cw'(Units + 1);
  localparam logic [Ew-1:0] ArenaMax = Ew'(ARENA_BYTES);
  localparam logic [Mw-1:0] ArenaLim = Mw'(ARENA_BYTES);

  state_t state_r, state_nxt;
  logic [31:0]   base_r;
  logic [Ew-1:0] total_r, total_nxt;
  logic [Aw-1:0] head_r, head_nxt;
  logic          head_v_r, head_v_nxt;
  logic [Aw-1:0] cur_r, cur_nxt, prev_r, prev_nxt, unit_r, unit_nxt;
  logic          cur_v_r, cur_v_nxt, prev_v_r, prev_v_nxt;
  logic [Cw-1:0] steps_r, steps_nxt;
  logic [Sw-1:0] need_r, need_nxt, usz_r, usz_nxt;
  logic [Aw:0]   unext_r, unext_nxt;
  logic [Sw-1:0] csz_r, csz_nxt;
  logic [Aw:0]   cnext_r, cnext_nxt;
  logic [Ew-1:0] end_r, end_nxt;
  logic [16:0]   req_r, req_nxt;
  logic [31:0]   addr_r, addr_nxt;
  out_word_t     res_r, res_nxt;
  out_word_t     out_r, out_nxt;
  logic          out_v_r, out_v_nxt;

  logic                 we;
  logic [Aw-1:0]        waddr, raddr;
  logic [Sw+Aw-1:0]     wdata, rdata;
  logic [Sw-1:0]        rd_size;
  logic [Aw-1:0]        rd_next;

  ffca_hdr_mem #(.Units(Units), .Aw(Aw), .Sw(Sw)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_size = rdata[Sw+Aw-1:Aw];
  assign rd_next = rdata[Aw-1:0];

  assign in_ready  = (state_r == ST_IDLE) && !cfg_we;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  logic [Mw-1:0] cfg_al;
  logic [Mw-1:0] need_w;
  logic [Ew-1:0] remain_w;
  logic [Aw+1:0] split_w;
  logic [31:0]   off_w;
  logic [29:0]   offu_w;
  logic [Ew-1:0] nb_w;

  always_comb begin
    cfg_al   = Mw'(({1'b0, cfg_wdata[16:0]} + 18'd7) & ~18'd7);
    need_w   = Mw'(({1'b0, req_r} + 18'd7) & ~18'd7);
    remain_w = {1'b0, rd_size} - {1'b0, need_r};
    split_w  = (Aw+2)'(cur_r) + (Aw+2)'(1) + (Aw+2)'(need_r >> 3);
    off_w    = addr_r - base_r;
    offu_w   = {1'b0, off_w[31:3]} - 30'd1;
    nb_w     = Ew'({unit_r, 3'b000}) + Ew'(8) + Ew'(rd_size);
  end

  always_comb begin
    state_nxt = state_r;
    total_nxt = total_r; head_nxt = head_r; head_v_nxt = head_v_r;
    cur_nxt = cur_r; cur_v_nxt = cur_v_r; prev_nxt = prev_r; prev_v_nxt = prev_v_r;
    unit_nxt = unit_r; steps_nxt = steps_r; need_nxt = need_r; usz_nxt = usz_r;
    unext_nxt = unext_r; csz_nxt = csz_r; cnext_nxt = cnext_r; end_nxt = end_r;
    req_nxt = req_r; addr_nxt = addr_r;
    res_nxt = res_r; out_nxt = out_r; out_v_nxt = out_v_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = cur_r;

    if (out_v_r && out_ready) out_v_nxt = 1'b0;

    if (cfg_we && cfg_index == 2'(CFG_ARENA)) begin
      total_nxt = (cfg_al > ArenaLim) ? ArenaMax : Ew'(cfg_al);
      cur_nxt   = '0;
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR: begin
          we = 1'b1; waddr = cur_r;
          cur_nxt = cur_r + Aw'(1);
          if (cur_r == Aw'(Units - 1)) state_nxt = ST_INIT;
        end
        ST_INIT: begin
          if (total_r < Ew'(16)) begin
            head_v_nxt = 1'b0; head_nxt = '0;
          end else begin
            we = 1'b1; waddr = Aw'(1);
            wdata = {Sw'(total_r - Ew'(16)), Aw'(0)};
            head_v_nxt = 1'b1; head_nxt = Aw'(1);
          end
          state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_nxt = in_data.request_size;
            addr_nxt = in_data.block_address;
            cur_nxt = head_r; cur_v_nxt = head_v_r;
            prev_v_nxt = 1'b0; prev_nxt = '0; steps_nxt = '0;
            state_nxt = (in_data.cmd == CMD_FREE) ? ST_F_RD : ST_A_RD;
          end
        end
        ST_A_RD: begin
          need_nxt = Sw'(need_w);
          if (need_w > ArenaLim || !cur_v_r || cur_r == '0 || steps_r >= WalkLimit) begin
            res_nxt = '{result_address: 32'd0, ok: 1'b0};
            state_nxt = ST_DONE;
          end else begin
            raddr = cur_r; state_nxt = ST_A_CHK;
          end
        end
        ST_A_CHK: begin
          if ({1'b0, rd_size} >= {1'b0, need_r}) begin
            csz_nxt = rd_size; cnext_nxt = {1'b0, rd_next};
            res_nxt = '{result_address: base_r + 32'({cur_r, 3'b000}) + 32'd8, ok: 1'b1};
            if (remain_w > Ew'(8) && split_w < (Aw+2)'(Units)) state_nxt = ST_A_SPLIT;
            else begin
              unext_nxt = {1'b0, rd_next};
              state_nxt = ST_A_LINK;
            end
          end else begin
            prev_nxt = cur_r; prev_v_nxt = 1'b1;
            cur_nxt = rd_next; steps_nxt = steps_r + Cw'(1);
            state_nxt = ST_A_RD;
          end
        end
        ST_A_SPLIT: begin
          we = 1'b1; waddr = Aw'(split_w);
          wdata = {Sw'((csz_r - need_r - Sw'(8)) & ~Sw'(7)), cnext_r[Aw-1:0]};
          unext_nxt = {1'b0, Aw'(split_w)};
          state_nxt = ST_A_SIZE;
        end
        ST_A_SIZE: begin
          we = 1'b1; waddr = cur_r; wdata = {need_r, cnext_r[Aw-1:0]};
          state_nxt = ST_A_LINK;
        end
        ST_A_LINK: begin
          if (prev_v_r) begin
            raddr = prev_r;
            state_nxt = ST_F_PV_W;
          end else begin
            head_nxt = unext_r[Aw-1:0]; head_v_nxt = (unext_r != '0);
            state_nxt = ST_DONE;
          end
        end
        ST_F_RD: begin
          unit_nxt = Aw'(offu_w);
          if (addr_r == 32'd0 || off_w[2:0] != 3'd0 || off_w < 32'd16 ||
              offu_w >= 30'(Units)) begin
            res_nxt = '{result_address: 32'd0, ok: 1'b0};
            state_nxt = ST_DONE;
          end else begin
            raddr = Aw'(offu_w); state_nxt = ST_F_CHK;
          end
        end
        ST_F_CHK: begin
          usz_nxt = rd_size; end_nxt = nb_w;
          if (nb_w > total_r || ({1'b0, rd_size} + Ew'(8) + Ew'({unit_r, 3'b000})) > total_r ||
              rd_size > Sw'(ARENA_BYTES)) begin
            res_nxt = '{result_address: 32'd0, ok: 1'b0};
            state_nxt = ST_DONE;
          end else state_nxt = ST_F_WALK_RD;
        end
        ST_F_WALK_RD: begin
          if (cur_v_r && cur_r != '0 && cur_r < unit_r) begin
            if (steps_r >= WalkLimit) begin
              res_nxt = '{result_address: 32'd0, ok: 1'b0};
              state_nxt = ST_DONE;
            end else begin
              raddr = cur_r; state_nxt = ST_F_WALK;
            end
          end else begin
            if (!cur_v_r) cur_nxt = '0;
            if (cur_v_r && cur_r == unit_r) begin
              res_nxt = '{result_address: 32'd0, ok: 1'b0};
              state_nxt = ST_DONE;
            end else state_nxt = ST_F_INS;
          end
        end
        ST_F_WALK: begin
          prev_nxt = cur_r; prev_v_nxt = 1'b1; cur_nxt = rd_next;
          steps_nxt = steps_r + Cw'(1);
          state_nxt = ST_F_WALK_RD;
        end
        ST_F_INS: begin
          unext_nxt = {1'b0, cur_r};
          we = 1'b1; waddr = unit_r; wdata = {usz_r, cur_r};
          if (!prev_v_r) begin
            head_nxt = unit_r; head_v_nxt = 1'b1;
          end
          res_nxt = '{result_address: 32'd0, ok: 1'b1};
          state_nxt = ST_F_NX_RD;
        end
        ST_F_NX_RD: begin
          if (cur_r != '0 && end_r == Ew'({cur_r, 3'b000})) begin
            raddr = cur_r; state_nxt = ST_F_NX;
          end else state_nxt = ST_F_PV_RD;
        end
        ST_F_NX: begin
          usz_nxt = usz_r + Sw'(8) + rd_size;
          unext_nxt = {1'b0, rd_next};
          we = 1'b1; waddr = unit_r; wdata = {usz_r + Sw'(8) + rd_size, rd_next};
          state_nxt = ST_F_PV_RD;
        end
        ST_F_PV_RD: begin
          raddr = prev_r;
          state_nxt = prev_v_r ? ST_F_PV : ST_DONE;
        end
        ST_F_PV: begin
          if (Ew'({prev_r, 3'b000}) + Ew'(8) + Ew'(rd_size) == Ew'({unit_r, 3'b000})) begin
            we = 1'b1; waddr = prev_r;
            wdata = {rd_size + Sw'(8) + usz_r, unext_r[Aw-1:0]};
          end else begin
            we = 1'b1; waddr = prev_r; wdata = {rd_size, unit_r};
          end
          state_nxt = ST_DONE;
        end
        ST_F_PV_W: begin
          we = 1'b1; waddr = prev_r; wdata = {rd_size, unext_r[Aw-1:0]};
          state_nxt = ST_DONE;
        end
        ST_DONE: begin
          if (!out_v_r || out_ready) begin
            out_nxt = res_r;
            out_v_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      base_r <= '0; total_r <= ArenaMax;
      head_r <= '0; head_v_r <= 1'b0;
      cur_r <= '0; cur_v_r <= 1'b0; prev_v_r <= 1'b0; steps_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == 2'(CFG_BASE)) base_r <= cfg_wdata;
      total_r <= total_nxt;
      head_r <= head_nxt; head_v_r <= head_v_nxt;
      cur_r <= cur_nxt; cur_v_r <= cur_v_nxt; prev_v_r <= prev_v_nxt;
      steps_r <= steps_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt; unit_r <= unit_nxt; need_r <= need_nxt; usz_r <= usz_nxt;
    unext_r <= unext_nxt; csz_r <= csz_nxt; cnext_r <= cnext_nxt; end_r <= end_nxt;
    req_r <= req_nxt; addr_r <= addr_nxt; res_r <= res_nxt; out_r <= out_nxt;
  end
endmodule
